// ===== rtl/baro_pressure_compensation_unit_assert.svh =====
// assertion macros for the pressure compensation block
// BPC_ASSERT_IMP checks cons in the same cycle as ante, BPC_ASSERT_NXT in the cycle after
`ifndef BARO_PRESSURE_COMPENSATION_UNIT_ASSERT_SVH
`define BARO_PRESSURE_COMPENSATION_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define BPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pressure compensation check failed");
`define BPC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pressure compensation check failed");
`else
`define BPC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BPC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/bpc_pkg.sv =====
`timescale 1ns / 1ps
package bpc_pkg;

    // field widths
    localparam int RAW_W         = 24;
    localparam int OUT_W         = 32;
    localparam int COEF_WIDE_W   = 20;
    localparam int COEF_NARROW_W = 16;
    localparam int CFG_IDX_W     = 3;

    // fixed point
    localparam int FRAC      = 29;
    localparam int OUT_SHIFT = FRAC - 8;
    localparam int Q_W       = 32;
    localparam int Q_MAG_W   = 31;
    localparam int ACC1_W    = 48;
    localparam int TPP_W     = 2 * Q_W;
    localparam int TP_W      = 34;
    localparam int MX_W      = 34;
    localparam int MA_W      = 52;
    localparam int ACC_W     = 56;
    localparam int SPLIT_W   = 26;

    // scaling by 1024/7: q = 146*m + floor((2m+3)/7), the division by reciprocal
    localparam int SCALE_X_W   = RAW_W + 1;
    localparam int RECIP_W     = 26;
    localparam int RECIP_SHIFT = 28;
    localparam int SCALE_P_W   = SCALE_X_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_7   = 26'd38347923;
    localparam logic [7:0]         SCALE_INT = 8'd146;

    // pipeline depth
    localparam int MUL_LAT = 3;
    localparam int LATENCY = 2 + 2 + 2 * MUL_LAT + 1;

    // saturation bounds
    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_OFFSET = 3'd0,
        REG_COEF_P1     = 3'd1,
        REG_COEF_P2     = 3'd2,
        REG_COEF_P3     = 3'd3,
        REG_COEF_T1     = 3'd4,
        REG_COEF_TP1    = 3'd5,
        REG_COEF_TP2    = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [COEF_WIDE_W-1:0]   c00;
        logic [COEF_WIDE_W-1:0]   c10;
        logic [COEF_NARROW_W-1:0] c20;
        logic [COEF_NARROW_W-1:0] c30;
        logic [COEF_NARROW_W-1:0] c01;
        logic [COEF_NARROW_W-1:0] c11;
        logic [COEF_NARROW_W-1:0] c21;
    } coef_t;

    typedef struct packed {
        logic [Q_W-1:0] ps;
        logic [Q_W-1:0] ts;
    } scaled_t;

    typedef struct packed {
        logic [Q_W-1:0]    ps;
        logic [ACC1_W-1:0] tc01;
        logic [ACC1_W-1:0] acc1;
        logic [ACC1_W-1:0] accx;
        logic [TP_W-1:0]   tp;
    } prep_t;

endpackage

// ===== rtl/bpc_scale.sv =====
`timescale 1ns / 1ps
module bpc_scale (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           vld_in,
    input  logic [bpc_pkg::RAW_W-1:0]      p_raw,
    input  logic [bpc_pkg::RAW_W-1:0]      t_raw,
    output logic                           vld_out,
    output bpc_pkg::scaled_t               scaled
);

    localparam int LANES = 2;

    logic [LANES-1:0][bpc_pkg::RAW_W-1:0]     raw;
    logic [LANES-1:0]                         neg_next;
    logic [LANES-1:0]                         neg_reg;
    logic [LANES-1:0][bpc_pkg::RAW_W-1:0]     mag_next;
    logic [LANES-1:0][bpc_pkg::RAW_W-1:0]     mag_reg;
    logic [LANES-1:0][bpc_pkg::SCALE_X_W-1:0] x_val;
    logic [LANES-1:0][bpc_pkg::SCALE_P_W-1:0] prod_next;
    logic [LANES-1:0][bpc_pkg::SCALE_P_W-1:0] prod_reg;
    logic [LANES-1:0][bpc_pkg::Q_MAG_W-1:0]   q_mag;
    logic [LANES-1:0][bpc_pkg::Q_W-1:0]       q_next;
    logic [LANES-1:0][bpc_pkg::Q_W-1:0]       q_reg;
    logic                                     vld1_reg;
    logic                                     vld2_reg;

    assign raw[0] = p_raw;
    assign raw[1] = t_raw;

    // stage 1: magnitude and reciprocal product for the remainder part
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            neg_next[i]  = raw[i][bpc_pkg::RAW_W-1];
            mag_next[i]  = neg_next[i] ? (~raw[i] + 1'b1) : raw[i];
            x_val[i]     = {mag_next[i], 1'b0} + bpc_pkg::SCALE_X_W'(3);
            prod_next[i] = bpc_pkg::SCALE_P_W'(x_val[i])
                         * bpc_pkg::SCALE_P_W'(bpc_pkg::RECIP_7);
        end
    end

    // stage 2: integer part plus quotient, sign restored
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            q_mag[i] = bpc_pkg::Q_MAG_W'(mag_reg[i]) * bpc_pkg::Q_MAG_W'(bpc_pkg::SCALE_INT)
                     + bpc_pkg::Q_MAG_W'(prod_reg[i][bpc_pkg::SCALE_P_W-1:bpc_pkg::RECIP_SHIFT]);
            q_next[i] = neg_reg[i] ? -(bpc_pkg::Q_W'(q_mag[i])) : bpc_pkg::Q_W'(q_mag[i]);
        end
    end

    // valid pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= vld_in;
            vld2_reg <= vld1_reg;
        end
    end

    // data pipe
    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        mag_reg  <= mag_next;
        prod_reg <= prod_next;
        q_reg    <= q_next;
    end

    assign vld_out   = vld2_reg;
    assign scaled.ps = q_reg[0];
    assign scaled.ts = q_reg[1];

endmodule

// ===== rtl/bpc_prep.sv =====
`timescale 1ns / 1ps
module bpc_prep (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             vld_in,
    input  bpc_pkg::scaled_t scaled,
    input  bpc_pkg::coef_t   coef,
    output logic             vld_out,
    output bpc_pkg::prep_t   prep
);

    localparam int PW = bpc_pkg::ACC1_W;

    logic signed [PW-1:0]               p30_next;
    logic signed [PW-1:0]               p30_reg;
    logic signed [PW-1:0]               p21_next;
    logic signed [PW-1:0]               p21_reg;
    logic signed [PW-1:0]               tc01_next;
    logic signed [PW-1:0]               tc01_reg;
    logic signed [bpc_pkg::TPP_W-1:0]   tsps_next;
    logic signed [bpc_pkg::TPP_W-1:0]   tsps_reg;
    logic [bpc_pkg::Q_W-1:0]            ps_reg;
    bpc_pkg::prep_t                     prep_next;
    bpc_pkg::prep_t                     prep_reg;
    logic                               vld1_reg;
    logic                               vld2_reg;

    // stage 1: coefficient products and ts*ps
    always_comb
    begin
        p30_next  = PW'($signed(scaled.ps)) * PW'($signed(coef.c30));
        p21_next  = PW'($signed(scaled.ps)) * PW'($signed(coef.c21));
        tc01_next = PW'($signed(scaled.ts)) * PW'($signed(coef.c01));
        tsps_next = bpc_pkg::TPP_W'($signed(scaled.ts)) * bpc_pkg::TPP_W'($signed(scaled.ps));
    end

    // stage 2: add aligned coefficients, truncate ts*ps to q29
    always_comb
    begin
        prep_next.ps   = ps_reg;
        prep_next.tc01 = tc01_reg;
        prep_next.acc1 = (PW'($signed(coef.c20)) <<< bpc_pkg::FRAC) + p30_reg;
        prep_next.accx = (PW'($signed(coef.c11)) <<< bpc_pkg::FRAC) + p21_reg;
        prep_next.tp   = bpc_pkg::TP_W'(tsps_reg >>> bpc_pkg::FRAC);
    end

    // valid pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= vld_in;
            vld2_reg <= vld1_reg;
        end
    end

    // data pipe
    always_ff @(posedge clk)
    begin
        p30_reg  <= p30_next;
        p21_reg  <= p21_next;
        tc01_reg <= tc01_next;
        tsps_reg <= tsps_next;
        ps_reg   <= scaled.ps;
        prep_reg <= prep_next;
    end

    assign vld_out = vld2_reg;
    assign prep    = prep_reg;

endmodule

// ===== rtl/bpc_mulq29.sv =====
`timescale 1ns / 1ps
module bpc_mulq29 (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              vld_in,
    input  logic signed [bpc_pkg::MX_W-1:0]   x,
    input  logic signed [bpc_pkg::MA_W-1:0]   a,
    input  logic signed [bpc_pkg::ACC_W-1:0]  addend,
    output logic                              vld_out,
    output logic signed [bpc_pkg::ACC_W-1:0]  y
);

    localparam int HI_W   = bpc_pkg::MA_W - bpc_pkg::SPLIT_W;
    localparam int PLO_W  = bpc_pkg::MX_W + bpc_pkg::SPLIT_W + 1;
    localparam int PHI_W  = bpc_pkg::MX_W + HI_W;
    localparam int PROD_W = bpc_pkg::MX_W + bpc_pkg::MA_W;

    logic [bpc_pkg::SPLIT_W-1:0]         a_lo;
    logic signed [HI_W-1:0]              a_hi;
    logic signed [PLO_W-1:0]             plo_next;
    logic signed [PLO_W-1:0]             plo_reg;
    logic signed [PHI_W-1:0]             phi_next;
    logic signed [PHI_W-1:0]             phi_reg;
    logic signed [PROD_W-1:0]            sum_next;
    logic signed [PROD_W-1:0]            sum_reg;
    logic signed [bpc_pkg::ACC_W-1:0]    y_next;
    logic signed [bpc_pkg::ACC_W-1:0]    y_reg;
    logic signed [bpc_pkg::ACC_W-1:0]    add1_reg;
    logic signed [bpc_pkg::ACC_W-1:0]    add2_reg;
    logic [bpc_pkg::MUL_LAT-1:0]         vld_reg;

    // stage 1: two partial products, low half of a taken unsigned
    assign a_lo = a[bpc_pkg::SPLIT_W-1:0];
    assign a_hi = a[bpc_pkg::MA_W-1:bpc_pkg::SPLIT_W];

    always_comb
    begin
        plo_next = PLO_W'(x) * PLO_W'($signed({1'b0, a_lo}));
        phi_next = PHI_W'(x) * PHI_W'(a_hi);
    end

    // stage 2: recombine to the full product
    always_comb
    begin
        sum_next = (PROD_W'(phi_reg) <<< bpc_pkg::SPLIT_W) + PROD_W'(plo_reg);
    end

    // stage 3: floor to q29 and add the addend
    always_comb
    begin
        y_next = bpc_pkg::ACC_W'(sum_reg >>> bpc_pkg::FRAC) + add2_reg;
    end

    // valid pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[bpc_pkg::MUL_LAT-2:0], vld_in};
        end
    end

    // data pipe
    always_ff @(posedge clk)
    begin
        plo_reg  <= plo_next;
        phi_reg  <= phi_next;
        add1_reg <= addend;
        sum_reg  <= sum_next;
        add2_reg <= add1_reg;
        y_reg    <= y_next;
    end

    assign vld_out = vld_reg[bpc_pkg::MUL_LAT-1];
    assign y       = y_reg;

endmodule

// ===== rtl/baro_pressure_compensation_unit.sv =====
`timescale 1ns / 1ps
// channel   | handshake              | payload
// ----------+------------------------+-------------------------------------------
// input     | start, busy            | pressure_raw, temperature_raw
// result    | done (one-cycle)       | pressure_q8, saturated
// config    | cfg_valid, cfg_ready   | cfg_index, cfg_data
//
// one item per cycle while busy is low; each result passes the scaling and prep stages,
// then the two chained q29 multiply units of three stages each and the output register
// busy is high during reset, is registered low once reset is released, then stays low
// results appear on done and cannot be held off; nothing in the pipe ever stalls
module baro_pressure_compensation_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [bpc_pkg::RAW_W-1:0]     pressure_raw,
    input  logic signed [bpc_pkg::RAW_W-1:0]     temperature_raw,
    output logic                                 done,
    output logic signed [bpc_pkg::OUT_W-1:0]     pressure_q8,
    output logic                                 saturated,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bpc_pkg::COEF_WIDE_W-1:0]      cfg_data
);

    `include "baro_pressure_compensation_unit_assert.svh"

    localparam int RES_W = bpc_pkg::ACC_W - bpc_pkg::OUT_SHIFT;

    logic                                busy_reg;
    bpc_pkg::coef_t                      coef_reg;
    bpc_pkg::coef_t                      coef_next;
    logic                                in_vld;
    logic                                sc_vld;
    bpc_pkg::scaled_t                    sc_data;
    logic                                pr_vld;
    bpc_pkg::prep_t                      pr_data;
    logic                                u1_vld;
    logic signed [bpc_pkg::ACC_W-1:0]    u1_y;
    logic                                u3_vld;
    logic signed [bpc_pkg::ACC_W-1:0]    u3_y;
    logic signed [bpc_pkg::Q_W-1:0]      ps_dly_reg [bpc_pkg::MUL_LAT];
    logic signed [bpc_pkg::ACC1_W-1:0]   tc01_dly_reg [bpc_pkg::MUL_LAT];
    logic signed [bpc_pkg::ACC_W-1:0]    u2_add;
    logic                                u2_vld;
    logic signed [bpc_pkg::ACC_W-1:0]    u2_y;
    logic signed [RES_W-1:0]             res_full;
    logic signed [bpc_pkg::OUT_W-1:0]    q8_next;
    logic                                sat_next;
    logic signed [bpc_pkg::OUT_W-1:0]    q8_reg;
    logic                                sat_reg;
    logic                                done_reg;

    // reset recovery
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    assign busy      = busy_reg;
    assign cfg_ready = !busy_reg;
    assign in_vld    = start && !busy_reg;

    // coefficient registers, upper data bits dropped for narrow ones
    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bpc_pkg::REG_COEF_OFFSET: coef_next.c00 = cfg_data;
                bpc_pkg::REG_COEF_P1:     coef_next.c10 = cfg_data;
                bpc_pkg::REG_COEF_P2:     coef_next.c20 = cfg_data[bpc_pkg::COEF_NARROW_W-1:0];
                bpc_pkg::REG_COEF_P3:     coef_next.c30 = cfg_data[bpc_pkg::COEF_NARROW_W-1:0];
                bpc_pkg::REG_COEF_T1:     coef_next.c01 = cfg_data[bpc_pkg::COEF_NARROW_W-1:0];
                bpc_pkg::REG_COEF_TP1:    coef_next.c11 = cfg_data[bpc_pkg::COEF_NARROW_W-1:0];
                bpc_pkg::REG_COEF_TP2:    coef_next.c21 = cfg_data[bpc_pkg::COEF_NARROW_W-1:0];
                default:                  coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    // raw samples to q3.29
    bpc_scale u_scale (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (in_vld),
        .p_raw   (pressure_raw),
        .t_raw   (temperature_raw),
        .vld_out (sc_vld),
        .scaled  (sc_data)
    );

    // coefficient products and inner horner term
    bpc_prep u_prep (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (sc_vld),
        .scaled  (sc_data),
        .coef    (coef_reg),
        .vld_out (pr_vld),
        .prep    (pr_data)
    );

    // c10 + ps*acc1
    bpc_mulq29 u_mul_p1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (pr_vld),
        .x       (bpc_pkg::MX_W'($signed(pr_data.ps))),
        .a       (bpc_pkg::MA_W'($signed(pr_data.acc1))),
        .addend  (bpc_pkg::ACC_W'($signed(coef_reg.c10)) <<< bpc_pkg::FRAC),
        .vld_out (u1_vld),
        .y       (u1_y)
    );

    // tp*(c11 + ps*c21), in parallel
    bpc_mulq29 u_mul_tp (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (pr_vld),
        .x       (bpc_pkg::MX_W'($signed(pr_data.tp))),
        .a       (bpc_pkg::MA_W'($signed(pr_data.accx))),
        .addend  ('0),
        .vld_out (u3_vld),
        .y       (u3_y)
    );

    // delay ps and ts*c01 to meet the first unit's output
    always_ff @(posedge clk)
    begin
        ps_dly_reg[0]   <= $signed(pr_data.ps);
        tc01_dly_reg[0] <= $signed(pr_data.tc01);
        for (int i = 1; i < bpc_pkg::MUL_LAT; i++)
        begin
            ps_dly_reg[i]   <= ps_dly_reg[i-1];
            tc01_dly_reg[i] <= tc01_dly_reg[i-1];
        end
    end

    // c00 + ts*c01 + cross term, added in with the outer horner step
    assign u2_add = (bpc_pkg::ACC_W'($signed(coef_reg.c00)) <<< bpc_pkg::FRAC)
                  + bpc_pkg::ACC_W'(tc01_dly_reg[bpc_pkg::MUL_LAT-1])
                  + u3_y;

    bpc_mulq29 u_mul_p2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (u1_vld && u3_vld),
        .x       (bpc_pkg::MX_W'(ps_dly_reg[bpc_pkg::MUL_LAT-1])),
        .a       (bpc_pkg::MA_W'(u1_y)),
        .addend  (u2_add),
        .vld_out (u2_vld),
        .y       (u2_y)
    );

    // q29 to q24.8 with saturation
    always_comb
    begin
        res_full = RES_W'(u2_y >>> bpc_pkg::OUT_SHIFT);
        sat_next = 1'b0;
        q8_next  = bpc_pkg::OUT_W'(res_full);
        if (res_full > RES_W'(bpc_pkg::OUT_MAX))
        begin
            q8_next  = bpc_pkg::OUT_MAX;
            sat_next = 1'b1;
        end
        else if (res_full < RES_W'(bpc_pkg::OUT_MIN))
        begin
            q8_next  = bpc_pkg::OUT_MIN;
            sat_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= u2_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        q8_reg  <= q8_next;
        sat_reg <= sat_next;
    end

    assign done        = done_reg;
    assign pressure_q8 = q8_reg;
    assign saturated   = sat_reg;

    // checks
    `BPC_ASSERT_IMP(a_done_after_item, clk, rst_n, done, $past(start && !busy, bpc_pkg::LATENCY))
    `BPC_ASSERT_IMP(a_sat_on_bound, clk, rst_n, done && saturated, pressure_q8 == bpc_pkg::OUT_MAX || pressure_q8 == bpc_pkg::OUT_MIN)
    `BPC_ASSERT_NXT(a_busy_only_reset, clk, rst_n, !busy, !busy)

endmodule
